/* rtl/core/scf_pkg.sv */
`timescale 1ns / 1ps
package scf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int HALF_WIN   = 5;
    localparam int WIN        = 2 * HALF_WIN + 1;
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = 10;
    localparam int COORD_W    = 16;
    localparam int RANGE_W    = 16;
    localparam int RESP_W     = 20;
    localparam int DIFF_W     = RESP_W + 1;
    localparam int THRESH_W   = 17;
    localparam int RAD_W      = 32;
    localparam int ROOT_STEPS = RANGE_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int RAMP_STEP  = 50;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(600);

    typedef enum logic [1:0] {
        KIND_MAX = 2'd0,
        KIND_MIN = 2'd1,
        KIND_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TAP_NONE,
        TAP_PLUS,
        TAP_MINUS,
        TAP_MINUS2
    } tap_weight_t;

    typedef struct packed {
        logic              load;
        logic              mul_x;
        logic              mul_y;
        logic              root_init;
        logic              root_step;
        logic [STEP_W-1:0] step;
        logic              push_point;
        logic              flush_init;
        logic              push_ramp;
        logic              emit_cand;
        logic              emit_end;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic last;
        logic push_decide;
        logic hit;
        logic out_busy;
        logic flush_done;
        logic flush_decide;
    } status_t;

    // weight of the old window entry that lands at each tap after the shift
    function automatic tap_weight_t tap_weight(input logic [STEP_W-1:0] tap);
        tap_weight_t w;
        unique case (tap)
            4'd1, 4'd2, 4'd3, 4'd9, 4'd10: w = TAP_PLUS;
            4'd4, 4'd5, 4'd7, 4'd8:        w = TAP_MINUS;
            4'd6:                          w = TAP_MINUS2;
            default:                       w = TAP_NONE;
        endcase
        return w;
    endfunction

    function automatic logic signed [RESP_W-1:0] ramp_resp(input logic [COUNT_W-1:0] m);
        logic [RESP_W-1:0] p;
        p = RESP_W'(m) * RESP_W'(RAMP_STEP);
        return signed'(p);
    endfunction

endpackage

/* rtl/core/scf_point_if.sv */
`timescale 1ns / 1ps
interface scf_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [scf_pkg::COORD_W-1:0] x_mm;
    logic signed [scf_pkg::COORD_W-1:0] y_mm;
    logic                                last_point;

    modport source (output valid, output x_mm, output y_mm, output last_point, input ready);
    modport sink   (input valid, input x_mm, input y_mm, input last_point, output ready);
endinterface

/* rtl/core/scf_cand_if.sv */
`timescale 1ns / 1ps
interface scf_cand_if;
    logic                      valid;
    logic                      ready;
    logic [scf_pkg::IDX_W-1:0] point_index;
    logic [1:0]                extremum_kind;
    logic                      scan_end;

    modport source (output valid, output point_index, output extremum_kind, output scan_end,
                    input ready);
    modport sink   (input valid, input point_index, input extremum_kind, input scan_end,
                    output ready);
endinterface

/* rtl/core/scf_datapath.sv */
`timescale 1ns / 1ps
module scf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  scf_pkg::cmd_t                        cmd,
    output scf_pkg::status_t                     st,
    input  logic signed [scf_pkg::COORD_W-1:0]   x_mm,
    input  logic signed [scf_pkg::COORD_W-1:0]   y_mm,
    input  logic                                 last_point,
    input  logic                                 cfg_wr_en,
    input  logic [scf_pkg::THRESH_W-1:0]         cfg_wr_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [scf_pkg::IDX_W-1:0]            out_index,
    output logic [1:0]                           out_kind,
    output logic                                 out_end
);

    logic signed [scf_pkg::COORD_W-1:0]   x_reg;
    logic signed [scf_pkg::COORD_W-1:0]   y_reg;
    logic                                 last_reg;
    logic [scf_pkg::RAD_W-2:0]            mul_reg;
    logic [scf_pkg::RAD_W-1:0]            rad_reg;
    logic [scf_pkg::RAD_W-1:0]            root_reg;
    logic signed [scf_pkg::RESP_W-1:0]    acc_reg;
    logic [scf_pkg::RANGE_W-1:0]          range_reg [scf_pkg::WIN];
    logic signed [scf_pkg::RESP_W-1:0]    resp_reg [scf_pkg::WIN];
    logic [scf_pkg::COUNT_W-1:0]          count_reg;
    logic [scf_pkg::COUNT_W-1:0]          fm_reg;
    logic [scf_pkg::IDX_W-1:0]            dec_idx_reg;
    logic [scf_pkg::THRESH_W-1:0]         thresh_reg;
    logic                                 out_valid_reg;
    logic [scf_pkg::IDX_W-1:0]            out_index_reg;
    logic [1:0]                           out_kind_reg;
    logic                                 out_end_reg;

    logic signed [scf_pkg::COORD_W-1:0]   mul_op;
    logic signed [2*scf_pkg::COORD_W-1:0] mul_full;
    logic [scf_pkg::RAD_W-1:0]            root_bit;
    logic [scf_pkg::RAD_W-1:0]            trial;
    logic [scf_pkg::STEP_W-1:0]           tap_idx;
    logic signed [scf_pkg::RESP_W-1:0]    tap_ext;
    logic signed [scf_pkg::RESP_W-1:0]    acc_next;
    logic [scf_pkg::RANGE_W-1:0]          root16;
    logic [scf_pkg::COUNT_W-1:0]          m_pt;
    logic signed [scf_pkg::RESP_W-1:0]    pt_resp;
    logic signed [scf_pkg::RESP_W-1:0]    resp_in;
    logic                                 resp_push;
    logic signed [scf_pkg::DIFF_W-1:0]    thr_s;
    logic signed [scf_pkg::DIFF_W-1:0]    diff [scf_pkg::WIN];
    logic                                 is_max;
    logic                                 is_min;
    logic                                 any_above;
    logic                                 any_below;
    logic                                 hit_max;
    logic                                 hit_min;

    // shared squarer
    assign mul_op   = cmd.mul_y ? y_reg : x_reg;
    assign mul_full = mul_op * mul_op;

    // one restoring square root step
    assign root_bit = {2'b01, {(scf_pkg::RAD_W-2){1'b0}}} >> {cmd.step, 1'b0};
    assign trial    = root_reg + root_bit;

    // response partial sum over the old window while the root runs
    assign tap_idx = cmd.step + scf_pkg::STEP_W'(1);
    assign tap_ext = signed'({{(scf_pkg::RESP_W-scf_pkg::RANGE_W){1'b0}}, range_reg[tap_idx]});

    always_comb
    begin
        unique case (scf_pkg::tap_weight(tap_idx))
            scf_pkg::TAP_PLUS:   acc_next = acc_reg + tap_ext;
            scf_pkg::TAP_MINUS:  acc_next = acc_reg - tap_ext;
            scf_pkg::TAP_MINUS2: acc_next = acc_reg - (tap_ext <<< 1);
            default:             acc_next = acc_reg;
        endcase
    end

    assign root16  = root_reg[scf_pkg::RANGE_W-1:0];
    assign m_pt    = count_reg - scf_pkg::COUNT_W'(scf_pkg::HALF_WIN);
    assign pt_resp = (m_pt < scf_pkg::COUNT_W'(scf_pkg::HALF_WIN))
                   ? scf_pkg::ramp_resp(m_pt)
                   : acc_reg + signed'({{(scf_pkg::RESP_W-scf_pkg::RANGE_W){1'b0}}, root16});
    assign resp_in   = cmd.push_ramp ? scf_pkg::ramp_resp(fm_reg) : pt_resp;
    assign resp_push = cmd.push_ramp
                    || (cmd.push_point && count_reg >= scf_pkg::COUNT_W'(scf_pkg::HALF_WIN));

    // extremum test on the window centre
    assign thr_s = signed'({{(scf_pkg::DIFF_W-scf_pkg::THRESH_W){1'b0}}, thresh_reg});

    always_comb
    begin
        is_max    = 1'b1;
        is_min    = 1'b1;
        any_above = 1'b0;
        any_below = 1'b0;
        for (int j = 0; j < scf_pkg::WIN; j++)
        begin
            diff[j] = scf_pkg::DIFF_W'(resp_reg[scf_pkg::HALF_WIN])
                    - scf_pkg::DIFF_W'(resp_reg[j]);
            if (diff[j] > thr_s)
            begin
                any_above = 1'b1;
            end
            if (diff[j] < -thr_s)
            begin
                any_below = 1'b1;
            end
            if (j >= scf_pkg::HALF_WIN - 2 && j <= scf_pkg::HALF_WIN + 2
                && j != scf_pkg::HALF_WIN)
            begin
                if (!(diff[j] > 0))
                begin
                    is_max = 1'b0;
                end
                if (!(diff[j] < 0))
                begin
                    is_min = 1'b0;
                end
            end
        end
    end

    assign hit_max = is_max && any_above;
    assign hit_min = is_min && any_below;

    assign st.drop         = count_reg >= scf_pkg::COUNT_W'(scf_pkg::MAX_POINTS);
    assign st.last         = last_reg;
    assign st.push_decide  = count_reg >= scf_pkg::COUNT_W'(3 * scf_pkg::HALF_WIN);
    assign st.hit          = hit_max || hit_min;
    assign st.out_busy     = out_valid_reg && !out_ready;
    assign st.flush_done   = fm_reg == count_reg;
    assign st.flush_decide = fm_reg >= scf_pkg::COUNT_W'(2 * scf_pkg::HALF_WIN);

    // control and windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            thresh_reg    <= scf_pkg::THRESH_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < scf_pkg::WIN; i++)
            begin
                range_reg[i] <= '0;
                resp_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                last_reg <= last_point;
            end
            if (cmd.emit_cand || cmd.emit_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit_end)
            begin
                count_reg <= '0;
                for (int i = 0; i < scf_pkg::WIN; i++)
                begin
                    range_reg[i] <= '0;
                    resp_reg[i]  <= '0;
                end
            end
            else
            begin
                if (cmd.push_point)
                begin
                    count_reg <= count_reg + scf_pkg::COUNT_W'(1);
                    for (int i = 0; i < scf_pkg::WIN - 1; i++)
                    begin
                        range_reg[i] <= range_reg[i+1];
                    end
                    range_reg[scf_pkg::WIN-1] <= root16;
                end
                if (resp_push)
                begin
                    for (int i = 0; i < scf_pkg::WIN - 1; i++)
                    begin
                        resp_reg[i] <= resp_reg[i+1];
                    end
                    resp_reg[scf_pkg::WIN-1] <= resp_in;
                end
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= x_mm;
            y_reg <= y_mm;
        end
        if (cmd.mul_x || cmd.mul_y)
        begin
            mul_reg <= mul_full[scf_pkg::RAD_W-2:0];
        end
        if (cmd.mul_y)
        begin
            rad_reg <= {1'b0, mul_reg};
        end
        else if (cmd.root_init)
        begin
            rad_reg <= rad_reg + {1'b0, mul_reg};
        end
        else if (cmd.root_step && rad_reg >= trial)
        begin
            rad_reg <= rad_reg - trial;
        end
        if (cmd.root_init)
        begin
            root_reg <= '0;
            acc_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            acc_reg <= acc_next;
            if (rad_reg >= trial)
            begin
                root_reg <= (root_reg >> 1) + root_bit;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
        if (cmd.flush_init)
        begin
            fm_reg <= (count_reg > scf_pkg::COUNT_W'(scf_pkg::HALF_WIN))
                    ? count_reg - scf_pkg::COUNT_W'(scf_pkg::HALF_WIN) : '0;
        end
        else if (cmd.push_ramp)
        begin
            fm_reg <= fm_reg + scf_pkg::COUNT_W'(1);
        end
        if (cmd.push_point)
        begin
            dec_idx_reg <= scf_pkg::IDX_W'(m_pt - scf_pkg::COUNT_W'(scf_pkg::HALF_WIN));
        end
        else if (cmd.push_ramp)
        begin
            dec_idx_reg <= scf_pkg::IDX_W'(fm_reg - scf_pkg::COUNT_W'(scf_pkg::HALF_WIN));
        end
        if (cmd.emit_cand)
        begin
            out_index_reg <= dec_idx_reg;
            out_kind_reg  <= hit_max ? scf_pkg::KIND_MAX : scf_pkg::KIND_MIN;
            out_end_reg   <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            out_index_reg <= '0;
            out_kind_reg  <= scf_pkg::KIND_END;
            out_end_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_kind  = out_kind_reg;
    assign out_end   = out_end_reg;

endmodule

/* rtl/core/scf_ctrl.sv */
`timescale 1ns / 1ps
module scf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  scf_pkg::status_t st,
    output scf_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_ROOT_INIT,
        S_ROOT,
        S_PUSH,
        S_DECIDE,
        S_FLUSH_INIT,
        S_FLUSH,
        S_END
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [scf_pkg::STEP_W-1:0]  step_reg;
    logic [scf_pkg::STEP_W-1:0]  step_next;
    logic                        flush_reg;
    logic                        flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            flush_reg <= flush_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        flush_next = flush_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!st.drop)
                    begin
                        state_next = S_MUL_X;
                    end
                    else if (in_last)
                    begin
                        state_next = S_FLUSH_INIT;
                    end
                end
            end
            S_MUL_X:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_ROOT_INIT;
            end
            S_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                step_next     = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cmd.step      = step_reg;
                step_next     = step_reg + scf_pkg::STEP_W'(1);
                if (step_reg == scf_pkg::STEP_W'(scf_pkg::ROOT_STEPS - 1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push_point = 1'b1;
                if (st.push_decide)
                begin
                    state_next = S_DECIDE;
                end
                else if (st.last)
                begin
                    state_next = S_FLUSH_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DECIDE:
            begin
                if (!st.hit || !st.out_busy)
                begin
                    cmd.emit_cand = st.hit;
                    if (flush_reg)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (st.last)
                    begin
                        state_next = S_FLUSH_INIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH_INIT:
            begin
                cmd.flush_init = 1'b1;
                flush_next     = 1'b1;
                state_next     = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (st.flush_done)
                begin
                    state_next = S_END;
                end
                else
                begin
                    cmd.push_ramp = 1'b1;
                    if (st.flush_decide)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_END:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit_end = 1'b1;
                    flush_next   = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/scan_curb_candidate_finder.sv */
`timescale 1ns / 1ps
// a stored point passes from acceptance to the next ready through 2 squaring steps,
// 1 root setup, 16 shared square root steps, 1 push and 1 decide that registers a candidate
// the first 15 points of a scan skip the decide; a full output register stalls
// a dropped point past the point limit is not stored, and unless it is last, ready stays high
// a last point adds a flush setup and a ramp push per flushed index, the end item comes last
// reset clears the range and response windows and the point count, threshold resets to 600
module scan_curb_candidate_finder (
    input  logic                          clk,
    input  logic                          rst_n,
    scf_point_if.sink                     points,
    scf_cand_if.source                    cands,
    input  logic                          cfg_wr_en,
    input  logic [scf_pkg::THRESH_W-1:0]  cfg_wr_data
);

    scf_pkg::cmd_t    cmd;
    scf_pkg::status_t st;

    scf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_last  (points.last_point),
        .in_ready (points.ready),
        .st       (st),
        .cmd      (cmd)
    );

    scf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .x_mm        (points.x_mm),
        .y_mm        (points.y_mm),
        .last_point  (points.last_point),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (cands.ready),
        .out_valid   (cands.valid),
        .out_index   (cands.point_index),
        .out_kind    (cands.extremum_kind),
        .out_end     (cands.scan_end)
    );

endmodule

/* test/scan_curb_candidate_finder_test.sv */
`timescale 1ns / 1ps
module scan_curb_candidate_finder_test;
    import scf_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } scan_point_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        kind_t            kind;
        logic             scan_end;
    } cand_rec_t;

    typedef enum int {
        SCAN_CURB,
        SCAN_NOISE,
        SCAN_EXTREME
    } scan_style_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;

    scf_point_if points ();
    scf_cand_if  cands ();

    scan_curb_candidate_finder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .points      (points),
        .cands       (cands),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // curb tracker state
    logic [THRESH_W-1:0]      thresh_model;
    logic [RANGE_W-1:0]       range_hist [WIN];
    logic signed [RESP_W-1:0] resp_hist [WIN];
    int unsigned              stored;

    scan_point_t point_feed [$];
    cand_rec_t   cand_due [$];
    int          points_owed;
    int          bad_items;
    scan_point_t cur_point;
    int          hold;
    int          stall;
    bit          steady_in;
    bit          steady_out;

    function automatic logic [RANGE_W-1:0] root_floor(input longint v);
        logic [RANGE_W-1:0] res;
        logic [RANGE_W-1:0] cand;
        res = '0;
        for (int b = RANGE_W - 1; b >= 0; b--)
        begin
            cand = res | (RANGE_W'(1) << b);
            if (longint'(cand) * longint'(cand) <= v)
                res = cand;
        end
        return res;
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < WIN; i++)
        begin
            range_hist[i] = '0;
            resp_hist[i] = '0;
        end
        stored = 0;
    endfunction

    function automatic void push_resp(input int r);
        for (int i = 0; i < WIN - 1; i++)
            resp_hist[i] = resp_hist[i + 1];
        resp_hist[WIN - 1] = RESP_W'(r);
    endfunction

    // centre of the response history holds index d
    function automatic void judge_center(input int unsigned d);
        longint    c;
        longint    lim;
        longint    diff;
        bit        is_max;
        bit        is_min;
        bit        got_max;
        bit        got_min;
        cand_rec_t e;
        c = resp_hist[HALF_WIN];
        lim = thresh_model;
        is_max = 1;
        is_min = 1;
        got_max = 0;
        got_min = 0;
        for (int j = HALF_WIN - 2; j <= HALF_WIN + 2; j++)
        begin
            if (j != HALF_WIN)
            begin
                if (!(c > resp_hist[j]))
                    is_max = 0;
                if (!(c < resp_hist[j]))
                    is_min = 0;
            end
        end
        if (is_max || is_min)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                diff = c - longint'(resp_hist[j]);
                if (is_max && diff > lim)
                    got_max = 1;
                else if (is_min && diff < -lim)
                    got_min = 1;
            end
            if (got_max || got_min)
            begin
                e.idx = d[IDX_W-1:0];
                e.kind = got_max ? KIND_MAX : KIND_MIN;
                e.scan_end = 1'b0;
                cand_due = {cand_due, e};
            end
        end
    endfunction

    function automatic void track_point(input scan_point_t p);
        longint      xs;
        longint      ys;
        int unsigned k;
        int unsigned m;
        int unsigned n;
        int          outer;
        int          inner;
        cand_rec_t   e;
        if (stored < MAX_POINTS)
        begin
            xs = p.x;
            ys = p.y;
            k = stored;
            for (int i = 0; i < WIN - 1; i++)
                range_hist[i] = range_hist[i + 1];
            range_hist[WIN - 1] = root_floor(xs * xs + ys * ys);
            stored++;
            if (k >= HALF_WIN)
            begin
                m = k - HALF_WIN;
                if (m < HALF_WIN)
                    push_resp(m * RAMP_STEP);
                else
                begin
                    outer = range_hist[10] + range_hist[9] + range_hist[8]
                          + range_hist[2] + range_hist[1] + range_hist[0];
                    inner = range_hist[7] + range_hist[6] + 2 * range_hist[5]
                          + range_hist[4] + range_hist[3];
                    push_resp(outer - inner);
                end
                if (m >= 2 * HALF_WIN)
                    judge_center(m - HALF_WIN);
            end
        end
        if (p.last)
        begin
            n = stored;
            m = (n > HALF_WIN) ? n - HALF_WIN : 0;
            while (m < n)
            begin
                push_resp(m * RAMP_STEP);
                if (m >= 2 * HALF_WIN)
                    judge_center(m - HALF_WIN);
                m++;
            end
            e.idx = '0;
            e.kind = KIND_END;
            e.scan_end = 1'b1;
            cand_due = {cand_due, e};
            clear_scan();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] corner();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic push_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
        scan_point_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        point_feed = {point_feed, p};
        points_owed++;
    endtask

    task automatic queue_scan(input int n, input scan_style_t style);
        int                        base;
        int                        rr;
        bit                        flip;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        base = $urandom_range(1500, 20000);
        flip = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                SCAN_CURB:
                begin
                    if ($urandom_range(0, 11) == 0)
                        base = base + int'($urandom_range(0, 6000)) - 3000;
                    if (base < 100)
                        base = 100;
                    if (base > 32000)
                        base = 32000;
                    rr = base + int'($urandom_range(0, 60)) - 30;
                    if ($urandom_range(0, 19) == 0)
                        rr = rr + int'($urandom_range(0, 4000)) - 2000;
                    if (rr < 0)
                        rr = 0;
                    if (rr > 32767)
                        rr = 32767;
                    a = COORD_W'(flip ? -rr : rr);
                    b = COORD_W'(int'($urandom_range(0, 800)) - 400);
                    if ($urandom_range(0, 1))
                        push_point(a, b, i == n - 1);
                    else
                        push_point(b, a, i == n - 1);
                end
                SCAN_NOISE:
                    push_point(COORD_W'($urandom), COORD_W'($urandom), i == n - 1);
                default:
                    push_point(corner(), corner(), i == n - 1);
            endcase
        end
    endtask

    // flat scan of 11 points with one odd range at the centre
    task automatic queue_probe(input int center_mm);
        for (int i = 0; i < 11; i++)
            push_point(COORD_W'(i == 5 ? center_mm : 1000), 16'sd0, i == 10);
    endtask

    task automatic drain();
        while (points_owed != 0 || cand_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (30) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        thresh_model = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        int          total;
        int          len;
        int          pick;
        scan_style_t style;
        total = 0;
        steady_in = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
        while (total < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = $urandom_range(1, 10);
            else if (pick < 85)
                len = $urandom_range(11, 40);
            else
                len = $urandom_range(41, 120);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                style = SCAN_CURB;
            else if (pick < 90)
                style = SCAN_NOISE;
            else
                style = SCAN_EXTREME;
            queue_scan(len, style);
            total += len;
            if ($urandom_range(0, 7) == 0)
                drain();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // point sender
    always @(posedge clk)
    begin
        bit load;
        load = 0;
        if (rst_n)
        begin
            if (points.valid && points.ready)
            begin
                track_point(cur_point);
                points_owed--;
                hold = steady_in ? 0 : pick_gap();
                load = (hold == 0);
            end
            else if (!points.valid)
            begin
                if (hold > 0)
                    hold--;
                else
                    load = 1;
            end
            if (load && point_feed.size() != 0)
            begin
                cur_point = point_feed.pop_front();
                points.valid <= 1'b1;
                points.x_mm <= cur_point.x;
                points.y_mm <= cur_point.y;
                points.last_point <= cur_point.last;
            end
            else if (points.valid && points.ready)
                points.valid <= 1'b0;
        end
    end

    // candidate receiver
    always @(posedge clk)
    begin
        cand_rec_t e;
        if (!rst_n)
            cands.ready <= 1'b0;
        else
        begin
            if (cands.valid && cands.ready)
            begin
                if (cand_due.size() == 0)
                begin
                    if (bad_items < 10)
                        $display("unexpected item: index %0d kind %0d end %0b",
                                 cands.point_index, cands.extremum_kind, cands.scan_end);
                    bad_items++;
                end
                else
                begin
                    e = cand_due.pop_front();
                    if (cands.point_index !== e.idx || cands.extremum_kind !== e.kind
                        || cands.scan_end !== e.scan_end)
                    begin
                        if (bad_items < 10)
                            $display({"item differs: expected index %0d kind %0d end %0b,",
                                      " got index %0d kind %0d end %0b"},
                                     e.idx, e.kind, e.scan_end, cands.point_index,
                                     cands.extremum_kind, cands.scan_end);
                        bad_items++;
                    end
                end
            end
            if (stall != 0)
            begin
                cands.ready <= 1'b0;
                stall--;
            end
            else if (!steady_out && $urandom_range(0, 4) == 0)
            begin
                cands.ready <= 1'b0;
                stall = pick_gap();
            end
            else
                cands.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        points.valid = 1'b0;
        points.x_mm = '0;
        points.y_mm = '0;
        points.last_point = 1'b0;
        cands.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        thresh_model = THRESH_RESET;
        points_owed = 0;
        bad_items = 0;
        hold = 0;
        stall = 0;
        steady_in = 0;
        steady_out = 0;
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // short scans at the coordinate extremes, then one minimum and one maximum
        push_point(-16'sd32768, -16'sd32768, 1'b1);
        push_point(16'sd32767, 16'sd32767, 1'b0);
        push_point(16'sd0, 16'sd0, 1'b0);
        push_point(-16'sd1, 16'sd1, 1'b1);
        queue_probe(5000);
        queue_probe(0);
        settle();

        set_threshold('0);
        random_phase(90);
        settle();
        set_threshold({THRESH_W{1'b1}});
        random_phase(90);
        settle();
        set_threshold(THRESH_W'($urandom_range(1, 3000)));
        random_phase(90);
        settle();
        set_threshold(THRESH_W'(50));
        random_phase(90);
        settle();

        if (bad_items == 0)
            $display("scan_curb_candidate_finder: match");
        else
            $display("scan_curb_candidate_finder: mismatch");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("scan_curb_candidate_finder: mismatch");
        $finish;
    end

endmodule
